FILE: hw/rtl/rfc_pkg.sv
package rfc_pkg;

  localparam int unsigned POS_W = 9;
  localparam logic [POS_W-1:0] POS_MAX = 9'd511;
  localparam logic [POS_W-1:0] FRAME_OVERHEAD = 9'd7;
  localparam logic [16:0] CHECK_BASE = 17'h10000;

  localparam logic [7:0] START_MARKER_RESET = 8'd221;
  localparam logic [7:0] END_MARKER_RESET = 8'd119;

  typedef enum logic {
    REG_START_MARKER = 1'b0,
    REG_END_MARKER   = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_VERDICT = 1'b1
  } item_kind_t;

  typedef struct packed {
    item_kind_t item_kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic       frame_good;
    logic [7:0] reply_command;
    logic [7:0] reply_status;
    logic [7:0] payload_length;
  } result_t;

endpackage

FILE: hw/rtl/rfc_parse.sv
module rfc_parse
  import rfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] start_marker,
  input  logic [7:0] end_marker,
  input  logic       step,
  input  logic [7:0] rx_byte,
  input  logic       buffer_last,
  output logic       res_valid,
  output result_t    res
);

  logic [POS_W-1:0] byte_position, byte_position_next;
  logic             opening_ok, opening_ok_next;
  logic [7:0]       saved_command, saved_command_next;
  logic [7:0]       saved_status, saved_status_next;
  logic [7:0]       saved_length, saved_length_next;
  logic [15:0]      running_sum, running_sum_next;
  logic [15:0]      received_check, received_check_next;

  logic             opening_cur;
  logic [7:0]       command_cur, status_cur, length_cur;
  logic [15:0]      sum_cur, sum_add, expected;
  logic             in_data, good;

  assign sum_add = running_sum + {8'd0, rx_byte};

  always_comb begin
    opening_cur = opening_ok;
    command_cur = saved_command;
    status_cur  = saved_status;
    length_cur  = saved_length;
    sum_cur     = running_sum;
    in_data     = 1'b0;
    if (byte_position == 9'd0) begin
      opening_cur = (rx_byte == start_marker);
    end else if (byte_position == 9'd1) begin
      command_cur = rx_byte;
    end else if (byte_position == 9'd2) begin
      status_cur = rx_byte;
      sum_cur    = sum_add;
    end else if (byte_position == 9'd3) begin
      length_cur = rx_byte;
      sum_cur    = sum_add;
    end else if (byte_position <= {1'b0, saved_length} + 9'd3) begin
      in_data = 1'b1;
      sum_cur = sum_add;
    end

    expected = 16'(CHECK_BASE - {1'b0, sum_cur});
    // total = position + 1, so the length checks are done on position
    good = opening_cur && (rx_byte == end_marker) && (byte_position < POS_MAX)
           && (byte_position >= FRAME_OVERHEAD - 9'd1)
           && (byte_position == {1'b0, length_cur} + FRAME_OVERHEAD - 9'd1)
           && (received_check == expected);

    res       = '0;
    res_valid = 1'b0;
    if (buffer_last) begin
      res_valid          = 1'b1;
      res.item_kind      = KIND_VERDICT;
      res.frame_good     = good;
      res.reply_command  = command_cur;
      res.reply_status   = status_cur;
      res.payload_length = length_cur;
    end else if (in_data) begin
      res_valid         = 1'b1;
      res.item_kind     = KIND_DATA;
      res.payload_byte  = rx_byte;
      res.payload_index = 8'(byte_position - 9'd4);
    end

    if (buffer_last) begin
      byte_position_next  = '0;
      opening_ok_next     = 1'b0;
      saved_command_next  = '0;
      saved_status_next   = '0;
      saved_length_next   = '0;
      running_sum_next    = '0;
      received_check_next = '0;
    end else begin
      byte_position_next  = (byte_position == POS_MAX) ? byte_position
                                                       : byte_position + 9'd1;
      opening_ok_next     = opening_cur;
      saved_command_next  = command_cur;
      saved_status_next   = status_cur;
      saved_length_next   = length_cur;
      running_sum_next    = sum_cur;
      received_check_next = {received_check[7:0], rx_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= '0;
      opening_ok     <= 1'b0;
      saved_command  <= '0;
      saved_status   <= '0;
      saved_length   <= '0;
      running_sum    <= '0;
      received_check <= '0;
    end else if (step) begin
      byte_position  <= byte_position_next;
      opening_ok     <= opening_ok_next;
      saved_command  <= saved_command_next;
      saved_status   <= saved_status_next;
      saved_length   <= saved_length_next;
      running_sum    <= running_sum_next;
      received_check <= received_check_next;
    end
  end

endmodule

FILE: hw/rtl/response_frame_checker.sv
// A result beat appears on the output in the cycle after its input beat is taken.
// Throughput: one byte per cycle while in_ready is high; the output register refills
// in the cycle it is drained, so in_ready only drops while a result is held and out_ready is low.
// Reset (rst, synchronous): frame state cleared, output empty, markers back to
// 0xDD (start) and 0x77 (end).
module response_frame_checker
  import rfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       buffer_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       item_kind,
  output logic [7:0] payload_byte,
  output logic [7:0] payload_index,
  output logic       frame_good,
  output logic [7:0] reply_command,
  output logic [7:0] reply_status,
  output logic [7:0] payload_length
);

  logic [7:0] start_marker;
  logic [7:0] end_marker;
  logic       step;
  logic       res_valid;
  result_t    res;
  result_t    out_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_marker <= START_MARKER_RESET;
      end_marker   <= END_MARKER_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_START_MARKER: start_marker <= cfg_data;
        REG_END_MARKER:   end_marker   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  rfc_parse u_parse (
    .clk          (clk),
    .rst          (rst),
    .start_marker (start_marker),
    .end_marker   (end_marker),
    .step         (step),
    .rx_byte      (rx_byte),
    .buffer_last  (buffer_last),
    .res_valid    (res_valid),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= step && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_reg <= res;
    end
  end

  assign item_kind      = out_reg.item_kind;
  assign payload_byte   = out_reg.payload_byte;
  assign payload_index  = out_reg.payload_index;
  assign frame_good     = out_reg.frame_good;
  assign reply_command  = out_reg.reply_command;
  assign reply_status   = out_reg.reply_status;
  assign payload_length = out_reg.payload_length;

endmodule

FILE: verif/response_frame_checker_tb.sv
module response_frame_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rfc_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } rx_beat_t;

  typedef enum int {
    FLAW_NONE,
    FLAW_START,
    FLAW_END,
    FLAW_CHECK,
    FLAW_CUT,
    FLAW_EXTRA
  } frame_flaw_t;

  // bit 8 flags the last byte of the buffer
  localparam logic [8:0] OPENING_BEATS [24] = '{
    9'h0DD, 9'h000, 9'h000, 9'h000, 9'h000, 9'h000, 9'h177,
    9'h1FF,
    9'h0DD, 9'h0FF, 9'h0FF, 9'h001, 9'h0FF, 9'h0FE, 9'h001, 9'h177,
    9'h0DD, 9'h012, 9'h134,
    9'h0DD, 9'h001, 9'h000, 9'h005, 9'h1AA
  };

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic       cfg_index = REG_START_MARKER;
  logic [7:0] cfg_data = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] rx_byte = 8'h00;
  logic       buffer_last = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic       item_kind;
  logic [7:0] payload_byte;
  logic [7:0] payload_index;
  logic       frame_good;
  logic [7:0] reply_command;
  logic [7:0] reply_status;
  logic [7:0] payload_length;

  response_frame_checker uut (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rx_byte        (rx_byte),
    .buffer_last    (buffer_last),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .item_kind      (item_kind),
    .payload_byte   (payload_byte),
    .payload_index  (payload_index),
    .frame_good     (frame_good),
    .reply_command  (reply_command),
    .reply_status   (reply_status),
    .payload_length (payload_length)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Marker copy and frame state of the checker as the bench sees it
  logic [7:0]  open_marker = START_MARKER_RESET;
  logic [7:0]  close_marker = END_MARKER_RESET;
  logic [8:0]  frame_pos = '0;
  logic        opening_seen = 1'b0;
  logic [7:0]  held_command = '0;
  logic [7:0]  held_status = '0;
  logic [7:0]  held_length = '0;
  logic [15:0] byte_sum = '0;
  logic [15:0] trailing_pair = '0;

  rx_beat_t rx_backlog[$];
  rx_beat_t on_bus;
  result_t  reply_items_due[$];
  result_t  oldest_due;
  int       beats_queued = 0;
  int       errors = 0;
  int       cycle_count = 0;
  bit       tx_gaps = 1'b0;
  bit       rx_gaps = 1'b0;
  int       hold_req = 0;
  int       hold_seen = 0;
  int       hold_left = 0;

  task automatic predict_reply_item(input logic [7:0] b, input logic last);
    logic [8:0]  p;
    logic [9:0]  total;
    logic        in_data;
    logic        good;
    logic [15:0] want_check;
    result_t     r;
    p = frame_pos;
    in_data = 1'b0;
    r = '0;
    if (p == 9'd0) begin
      opening_seen = (b == open_marker);
    end else if (p == 9'd1) begin
      held_command = b;
    end else if (p == 9'd2) begin
      held_status = b;
      byte_sum = byte_sum + {8'h00, b};
    end else if (p == 9'd3) begin
      held_length = b;
      byte_sum = byte_sum + {8'h00, b};
    end else if (p <= {1'b0, held_length} + 9'd3) begin
      in_data = 1'b1;
      byte_sum = byte_sum + {8'h00, b};
    end

    if (last) begin
      total = {1'b0, p} + 10'd1;
      want_check = 16'(CHECK_BASE - {1'b0, byte_sum});
      good = opening_seen && (b == close_marker) && (p != POS_MAX) &&
             (total >= 10'd7) && (total == {2'b00, held_length} + 10'd7) &&
             (trailing_pair == want_check);
      r.item_kind = KIND_VERDICT;
      r.frame_good = good;
      r.reply_command = held_command;
      r.reply_status = held_status;
      r.payload_length = held_length;
      reply_items_due.push_back(r);
      frame_pos = '0;
      opening_seen = 1'b0;
      held_command = '0;
      held_status = '0;
      held_length = '0;
      byte_sum = '0;
      trailing_pair = '0;
    end else begin
      trailing_pair = {trailing_pair[7:0], b};
      if (frame_pos != POS_MAX) frame_pos = frame_pos + 9'd1;
      if (in_data) begin
        r.item_kind = KIND_DATA;
        r.payload_byte = b;
        r.payload_index = 8'(p - 9'd4);
        reply_items_due.push_back(r);
      end
    end
  endtask

  // Sender: one beat held on the bus until taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_reply_item(on_bus.data, on_bus.last);
      if (!in_valid || in_ready) begin
        if (rx_backlog.size() != 0 && !(tx_gaps && $urandom_range(99) < 25)) begin
          on_bus = rx_backlog.pop_front();
          in_valid <= 1'b1;
          rx_byte <= on_bus.data;
          buffer_last <= on_bus.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  // Receiver: checks each beat, stalls at random or for a long hold when asked
  always @(posedge clk) begin
    if (out_valid && out_ready) begin
      if (reply_items_due.size() == 0) begin
        $error("result beat with nothing expected: kind %0d byte %0h", item_kind, payload_byte);
        errors++;
      end else begin
        oldest_due = reply_items_due.pop_front();
        check_field("item_kind", {7'd0, oldest_due.item_kind}, {7'd0, item_kind});
        check_field("payload_byte", oldest_due.payload_byte, payload_byte);
        check_field("payload_index", oldest_due.payload_index, payload_index);
        check_field("frame_good", {7'd0, oldest_due.frame_good}, {7'd0, frame_good});
        check_field("reply_command", oldest_due.reply_command, reply_command);
        check_field("reply_status", oldest_due.reply_status, reply_status);
        check_field("payload_length", oldest_due.payload_length, payload_length);
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(rx_gaps && $urandom_range(99) < 25);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("response_frame_checker verification failed");
      $finish;
    end
  end

  task automatic push_beat(input logic [7:0] b, input logic last);
    rx_beat_t t;
    t.data = b;
    t.last = last;
    rx_backlog.push_back(t);
    beats_queued++;
  endtask

  task automatic queue_frame(input int len, input frame_flaw_t flaw, input int extra);
    logic [7:0]  body[$];
    logic [7:0]  status;
    logic [7:0]  d;
    logic [15:0] sum16;
    logic [15:0] chk;
    int          cut;
    status = ($urandom_range(3) == 0) ? 8'h00 : 8'($urandom);
    body.push_back(flaw == FLAW_START ? open_marker ^ 8'($urandom_range(1, 255)) : open_marker);
    body.push_back(8'($urandom));
    body.push_back(status);
    body.push_back(8'(len));
    sum16 = {8'h00, status} + 16'(len);
    for (int i = 0; i < len; i++) begin
      d = 8'($urandom);
      body.push_back(d);
      sum16 = sum16 + {8'h00, d};
    end
    chk = 16'h0000 - sum16;
    if (flaw == FLAW_CHECK) chk = chk ^ 16'(1 << $urandom_range(0, 15));
    if (flaw == FLAW_EXTRA) begin
      repeat (extra) body.push_back(8'($urandom));
    end
    body.push_back(chk[15:8]);
    body.push_back(chk[7:0]);
    body.push_back(flaw == FLAW_END ? close_marker ^ 8'($urandom_range(1, 255)) : close_marker);
    if (flaw == FLAW_CUT) begin
      cut = $urandom_range(1, body.size() - 1);
      while (body.size() > cut) void'(body.pop_back());
    end
    foreach (body[i]) push_beat(body[i], i == body.size() - 1);
  endtask

  // Mostly well-formed frames with random content, some flawed, some loose noise
  task automatic run_random(input int count);
    int target;
    int len;
    int n;
    frame_flaw_t flaw;
    target = beats_queued + count;
    while (beats_queued < target) begin
      if ($urandom_range(99) < 80) begin
        len = ($urandom_range(99) < 90) ? $urandom_range(0, 12) : $urandom_range(13, 60);
        flaw = ($urandom_range(99) < 55) ? FLAW_NONE : frame_flaw_t'($urandom_range(1, 5));
        queue_frame(len, flaw, $urandom_range(1, 4));
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) push_beat(8'($urandom), i == n - 1 || $urandom_range(7) == 0);
      end
    end
  endtask

  task automatic wait_drained;
    do @(negedge clk);
    while (rx_backlog.size() != 0 || in_valid || reply_items_due.size() != 0);
    // header and checksum bytes leave no result, so let the pipe settle
    repeat (4) @(negedge clk);
  endtask

  task automatic write_markers(input logic [7:0] s, input logic [7:0] e);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_START_MARKER;
    cfg_data <= s;
    open_marker = s;
    @(posedge clk);
    cfg_index <= REG_END_MARKER;
    cfg_data <= e;
    close_marker = e;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  initial begin
    logic [7:0] shared;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (OPENING_BEATS[i]) push_beat(OPENING_BEATS[i][7:0], OPENING_BEATS[i][8]);
    wait_drained();

    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    hold_req++;
    queue_frame(255, FLAW_NONE, 0);
    run_random(120);
    wait_drained();

    write_markers(8'h00, 8'hFF);
    run_random(200);
    wait_drained();

    // long buffer runs the position counter into saturation
    write_markers(8'hFF, 8'h00);
    queue_frame(255, FLAW_EXTRA, 300);
    run_random(100);
    wait_drained();

    shared = 8'($urandom);
    write_markers(shared, shared);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    run_random(120);
    wait_drained();

    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    write_markers(8'($urandom), 8'($urandom));
    run_random(120);
    wait_drained();

    if (errors == 0) begin
      $display("response_frame_checker verification clean");
    end else begin
      $display("response_frame_checker verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/rfc_pkg.sv
hw/rtl/rfc_parse.sv
hw/rtl/response_frame_checker.sv
verif/response_frame_checker_tb.sv
